// ===== design/bitmap_run_length_word_encoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// Bitmap run-length word encoder: assertion macros
// Shared concurrent checks, all clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RUN_LENGTH_WORD_ENCODER_TOP_MACROS_SVH
`define BITMAP_RUN_LENGTH_WORD_ENCODER_TOP_MACROS_SVH

// Condition must hold at every clock edge
`define BRLE_CHK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define BRLE_CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BRLE_CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/brle_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap run-length word encoder: package
// Widths, run-kind codes and the result record shared by all modules.
// ----------------------------------------------------------------------------
package brle_pkg;

  localparam int WORD_BITS     = 32;
  localparam int RUN_BITS      = 30;
  localparam int IN_DATA_BITS  = 32;
  localparam int OUT_DATA_BITS = 64;
  localparam int OUT_USER_BITS = 1;

  localparam logic [RUN_BITS-1:0] MAX_RUN = 30'd1073741823;

  // Pending run kind
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ZERO = 2'd1;
  localparam logic [1:0] KIND_ONE  = 2'd2;

  // Result queue geometry
  localparam int RBUF_DEPTH    = 4;
  localparam int RBUF_PTR_BITS = 2;
  localparam int RBUF_CNT_BITS = 3;

  typedef struct packed {
    logic                 is_fill;
    logic                 fill_bit;
    logic [RUN_BITS-1:0]  run_words;
    logic [WORD_BITS-1:0] literal_word;
    logic                 last_of_item;
    logic                 stream_done;
  } res_t;

  // Results produced by one input word, up to two
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage

// ===== design/brle_core.sv =====
// ----------------------------------------------------------------------------
// Bitmap run-length word encoder: encode stage
// Input register, run state and the single-pass classify/flush logic.
// ----------------------------------------------------------------------------
`include "bitmap_run_length_word_encoder_top_macros.svh"

module brle_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [brle_pkg::IN_DATA_BITS-1:0]  in_tdata,
  input  logic                               in_tlast,
  input  logic                               room,
  output brle_pkg::push_t                    push
);
  import brle_pkg::*;

  logic                 in_valid_r, in_valid_nxt;
  logic [WORD_BITS-1:0] word_r;
  logic                 end_r;
  logic [1:0]           kind_r, kind_nxt;
  logic [RUN_BITS-1:0]  count_r, count_nxt;

  logic                 accept, proc_en;
  logic                 w_zero, w_one, is_lit, pend, extend, flush_old;
  logic                 emit_new, second_valid;
  logic [1:0]           new_kind;
  logic [RUN_BITS-1:0]  run_cnt;
  res_t                 old_res, new_res;

  // Input register handshake
  assign proc_en   = in_valid_r & room;
  assign in_tready = ~in_valid_r | room;
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (proc_en) begin
      in_valid_nxt = 1'b0;
    end
  end

  // Classify word against pending run
  assign w_zero   = (word_r == '0);
  assign w_one    = &word_r;
  assign is_lit   = ~w_zero & ~w_one;
  assign new_kind = w_one ? KIND_ONE : KIND_ZERO;
  assign pend     = ((kind_r == KIND_ZERO) || (kind_r == KIND_ONE)) && (count_r != '0);
  assign extend   = pend & ~is_lit & (kind_r == new_kind);
  assign flush_old = pend & ~extend;
  assign run_cnt  = extend ? (count_r + RUN_BITS'(1)) : RUN_BITS'(1);
  assign emit_new = ~is_lit & ((run_cnt >= MAX_RUN) | end_r);
  assign second_valid = is_lit | emit_new;

  // Build the result records
  always_comb begin
    old_res              = '0;
    old_res.is_fill      = 1'b1;
    old_res.fill_bit     = (kind_r == KIND_ONE);
    old_res.run_words    = count_r;
    old_res.last_of_item = ~second_valid;
    old_res.stream_done  = ~second_valid & end_r;

    new_res              = '0;
    new_res.is_fill      = ~is_lit;
    new_res.fill_bit     = ~is_lit & w_one;
    new_res.run_words    = is_lit ? '0 : run_cnt;
    new_res.literal_word = is_lit ? word_r : '0;
    new_res.last_of_item = 1'b1;
    new_res.stream_done  = end_r;

    push      = '0;
    push.res0 = flush_old ? old_res : new_res;
    push.res1 = new_res;
    if (proc_en) begin
      push.cnt = {1'b0, flush_old} + {1'b0, second_valid};
    end
  end

  // Run state update
  always_comb begin
    kind_nxt  = kind_r;
    count_nxt = count_r;
    if (proc_en) begin
      if (second_valid) begin
        kind_nxt  = KIND_NONE;
        count_nxt = '0;
      end else begin
        kind_nxt  = new_kind;
        count_nxt = run_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      kind_r     <= KIND_NONE;
      count_r    <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      kind_r     <= kind_nxt;
      count_r    <= count_nxt;
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_tdata[WORD_BITS-1:0];
      end_r  <= in_tlast;
    end
  end

  `BRLE_CHK_NEXT(a_end_clears_run, proc_en && end_r,
                 kind_r == KIND_NONE && count_r == '0, "run left pending after stream end")
  `BRLE_CHK_ALWAYS(a_run_below_max, count_r < MAX_RUN, "pending run reached maximum length")
  `BRLE_CHK_SAME(a_end_has_result, proc_en && end_r, push.cnt != 2'd0, "no result at end")

endmodule

// ===== design/brle_rbuf.sv =====
// ----------------------------------------------------------------------------
// Bitmap run-length word encoder: result queue
// Four-entry register queue taking up to two results a cycle, one out.
// ----------------------------------------------------------------------------
`include "bitmap_run_length_word_encoder_top_macros.svh"

module brle_rbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  brle_pkg::push_t  push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output brle_pkg::res_t   head
);
  import brle_pkg::*;

  res_t                     entry_r [RBUF_DEPTH];
  logic [RBUF_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RBUF_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RBUF_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [RBUF_PTR_BITS-1:0] wr_ptr_p1;
  logic                     pop;

  // Room for a worst-case two-result word
  assign room      = (cnt_r <= RBUF_CNT_BITS'(RBUF_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid & out_ready;
  assign head      = entry_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + RBUF_PTR_BITS'(1);

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RBUF_PTR_BITS'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + RBUF_PTR_BITS'(pop);
    cnt_nxt    = cnt_r + RBUF_CNT_BITS'(push.cnt) - RBUF_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry writes
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      entry_r[wr_ptr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      entry_r[wr_ptr_p1] <= push.res1;
    end
  end

  `BRLE_CHK_ALWAYS(a_cnt_in_range, cnt_r <= RBUF_CNT_BITS'(RBUF_DEPTH), "result queue overfilled")
  `BRLE_CHK_SAME(a_push_has_room, push.cnt != 2'd0, room, "results pushed without room")

endmodule

// ===== design/bitmap_run_length_word_encoder_top.sv =====
// ----------------------------------------------------------------------------
// Bitmap run-length word encoder: top level
// Encodes bitmap words into fill (run) and literal results.
//
//   Channel   Ports                         Contents
//   input     in_tvalid/tready/tdata/tlast  data_word; stream_end on tlast
//   result    out_tvalid/tready/tdata/      fill_bit, run_words, literal_word,
//             tuser/tlast                   last_of_item; is_fill; stream_done
//
// One word per cycle while the result queue has room; a request's first result
// reaches the output through the input register, then the result queue. A word
// that yields two results leaves the queue as two output transfers. in_tready
// drops while the input register is full and three or more results are queued.
// rst_n is synchronous: clears the run state and empties both stages.
// Output stalls back up through the four-entry result queue to in_tready.
// ----------------------------------------------------------------------------
module bitmap_run_length_word_encoder_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [brle_pkg::IN_DATA_BITS-1:0]   in_tdata,   // [31:0] data_word
  input  logic                                in_tlast,   // stream_end
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [brle_pkg::OUT_DATA_BITS-1:0]  out_tdata,  // [0] fill_bit, [30:1] run_words,
                                                          // [62:31] literal_word,
                                                          // [63] last_of_item
  output logic [brle_pkg::OUT_USER_BITS-1:0]  out_tuser,  // [0] is_fill
  output logic                                out_tlast   // stream_done
);
  import brle_pkg::*;

  push_t push;
  logic  room;
  res_t  head;

  brle_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .room      (room),
    .push      (push)
  );

  brle_rbuf u_rbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .head      (head)
  );

  // Output packing
  assign out_tdata = {head.last_of_item, head.literal_word, head.run_words, head.fill_bit};
  assign out_tuser = head.is_fill;
  assign out_tlast = head.stream_done;

endmodule
